### hw/rtl/ssort_pkg.sv
// Package for the Shell sort engine: sizes, memory request and emit types.
// Used by the interfaces, the sequencer and the top level; depends on nothing else.
package ssort_pkg;

    localparam int MAX_ELEMENTS = 64;
    localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = ADDR_W + 1;
    localparam int DATA_W       = 32;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr_a;
        logic [ADDR_W-1:0] raddr_b;
    } t_ram_req;

    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] value;
        logic                     last;
        logic                     drop;
    } t_emit;

endpackage

### hw/rtl/ssort_if.sv
// Valid/ready channel interfaces for input values and sorted results.
// Depends on ssort_pkg for the data width.
interface ssort_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [ssort_pkg::DATA_W-1:0] value;
    logic                              last_in;

    modport source (output valid, output value, output last_in, input ready);
    modport sink   (input valid, input value, input last_in, output ready);
endinterface

interface ssort_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [ssort_pkg::DATA_W-1:0] sorted_value;
    logic                              last_out;
    logic                              dropped;

    modport source (output valid, output sorted_value, output last_out, output dropped,
                    input ready);
    modport sink   (input valid, input sorted_value, input last_out, input dropped,
                    output ready);
endinterface

### hw/rtl/ssort_ram.sv
// Generic memory with one write port and two registered read ports.
// Self-contained; no package needed.
module ssort_ram #(
    parameter int ADDR_W = 6,
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [DATA_W-1:0] o_rdata_a,
    output logic [DATA_W-1:0] o_rdata_b
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= mem[i_raddr_a];
            o_rdata_b <= mem[i_raddr_b];
        end
    end

endmodule

### hw/rtl/ssort_seq.sv
// Sequencer that loads a set into the memory, runs the Shell sort passes
// and reads the sorted set out. Depends on ssort_pkg and ssort_in_if.
module ssort_seq (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    ssort_in_if.sink                        i_in,
    output ssort_pkg::t_ram_req             o_ram,
    input  logic [ssort_pkg::DATA_W-1:0]    i_rd_a,
    input  logic [ssort_pkg::DATA_W-1:0]    i_rd_b,
    output ssort_pkg::t_emit                o_emit,
    input  logic                            i_emit_take
);
    import ssort_pkg::*;

    typedef enum logic [2:0] {
        S_LOAD,
        S_RD,
        S_CMP,
        S_WR,
        S_ORD,
        S_OWAIT
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_ovf, n_ovf;
    logic [ADDR_W-1:0]  r_gap, n_gap;
    logic [CNT_W-1:0]   r_j, n_j;
    logic [ADDR_W-1:0]  r_i, n_i;
    logic [CNT_W-1:0]   r_k, n_k;
    logic [DATA_W-1:0]  r_hold, n_hold;

    logic               full;
    logic [CNT_W-1:0]   cnt_fin;
    logic [ADDR_W-1:0]  gap_fin;
    logic [ADDR_W-1:0]  gap_half;
    logic [ADDR_W-1:0]  addr_b;
    logic               j_last;
    logic               k_last;
    t_state             adv_state;
    logic [ADDR_W-1:0]  adv_gap;
    logic [CNT_W-1:0]   adv_j;
    logic [ADDR_W-1:0]  adv_i;
    logic [CNT_W-1:0]   adv_k;

    assign full     = (r_cnt == CNT_W'(MAX_ELEMENTS));
    assign cnt_fin  = full ? r_cnt : r_cnt + CNT_W'(1);
    assign gap_fin  = cnt_fin[CNT_W-1:1];
    assign gap_half = r_gap >> 1;
    assign addr_b   = r_i + r_gap;
    assign j_last   = (r_j + CNT_W'(1) == r_cnt);
    assign k_last   = (r_k + CNT_W'(1) == r_cnt);

    // Step to the next element of the pass, or to the next pass, or to read-out.
    always_comb begin
        adv_state = S_RD;
        adv_gap   = r_gap;
        adv_j     = r_j;
        adv_i     = r_i;
        adv_k     = r_k;
        if (!j_last) begin
            adv_j = r_j + CNT_W'(1);
            adv_i = ADDR_W'(r_j + CNT_W'(1) - {1'b0, r_gap});
        end else if (gap_half == '0) begin
            adv_state = S_ORD;
            adv_k     = '0;
        end else begin
            adv_gap = gap_half;
            adv_j   = {1'b0, gap_half};
            adv_i   = '0;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_ovf   = r_ovf;
        n_gap   = r_gap;
        n_j     = r_j;
        n_i     = r_i;
        n_k     = r_k;
        n_hold  = r_hold;

        o_ram.we      = 1'b0;
        o_ram.waddr   = r_i;
        o_ram.wdata   = i_in.value;
        o_ram.re      = 1'b0;
        o_ram.raddr_a = r_i;
        o_ram.raddr_b = addr_b;

        i_in.ready    = 1'b0;

        o_emit.valid  = 1'b0;
        o_emit.value  = $signed(i_rd_a);
        o_emit.last   = k_last;
        o_emit.drop   = r_ovf;

        case (r_state)
            S_LOAD: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    if (!full) begin
                        o_ram.we    = 1'b1;
                        o_ram.waddr = r_cnt[ADDR_W-1:0];
                        n_cnt       = r_cnt + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in.last_in) begin
                        n_cnt = cnt_fin;
                        if (gap_fin == '0) begin
                            n_state = S_ORD;
                            n_k     = '0;
                        end else begin
                            n_state = S_RD;
                            n_gap   = gap_fin;
                            n_j     = {1'b0, gap_fin};
                            n_i     = '0;
                        end
                    end
                end
            end
            S_RD: begin
                o_ram.re = 1'b1;
                n_state  = S_CMP;
            end
            S_CMP: begin
                if ($signed(i_rd_a) > $signed(i_rd_b)) begin
                    o_ram.we    = 1'b1;
                    o_ram.waddr = r_i;
                    o_ram.wdata = i_rd_b;
                    n_hold      = i_rd_a;
                    n_state     = S_WR;
                end else begin
                    n_state = adv_state;
                    n_gap   = adv_gap;
                    n_j     = adv_j;
                    n_i     = adv_i;
                    n_k     = adv_k;
                end
            end
            S_WR: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = addr_b;
                o_ram.wdata = r_hold;
                if (r_i < r_gap) begin
                    n_state = adv_state;
                    n_gap   = adv_gap;
                    n_j     = adv_j;
                    n_i     = adv_i;
                    n_k     = adv_k;
                end else begin
                    n_i     = r_i - r_gap;
                    n_state = S_RD;
                end
            end
            S_ORD: begin
                o_ram.re      = 1'b1;
                o_ram.raddr_a = r_k[ADDR_W-1:0];
                n_state       = S_OWAIT;
            end
            S_OWAIT: begin
                o_emit.valid = 1'b1;
                if (i_emit_take) begin
                    if (k_last) begin
                        n_cnt   = '0;
                        n_ovf   = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        n_k     = r_k + CNT_W'(1);
                        n_state = S_ORD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
        end
        r_gap  <= n_gap;
        r_j    <= n_j;
        r_i    <= n_i;
        r_k    <= n_k;
        r_hold <= n_hold;
    end

endmodule

### hw/rtl/shell_sort_engine.sv
// Top level of the Shell sort engine: sequencer, element memory and output register.
// Depends on ssort_pkg, ssort_if, ssort_ram and ssort_seq.
//
// The engine collects up to 64 signed values per set, one transfer per cycle,
// and on the value marked last sorts the set in ascending order with a Shell
// sort whose gap starts at half the count and halves each pass. Values that
// arrive once the set is full are dropped, and every result of that set then
// carries the dropped flag. All work goes through one memory with one write
// port and two registered read ports, so each compare goes through S_RD and
// S_CMP and each swap adds S_WR. No input is taken from the last value of
// a set until the last sorted value has moved into the output register;
// read-out reads each value in S_ORD and offers it in S_OWAIT until the
// output register takes it. A set thus passes through loading, the sort
// passes and read-out. No clearing pass follows reset.
module shell_sort_engine (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ssort_in_if.sink  i_in,
    ssort_out_if.source o_out
);
    import ssort_pkg::*;

    t_ram_req           ram_req;
    logic [DATA_W-1:0]  rd_a;
    logic [DATA_W-1:0]  rd_b;
    t_emit              emit;
    logic               emit_take;

    logic                      r_valid;
    logic signed [DATA_W-1:0]  r_value;
    logic                      r_last;
    logic                      r_drop;

    ssort_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_ram       (ram_req),
        .i_rd_a      (rd_a),
        .i_rd_b      (rd_b),
        .o_emit      (emit),
        .i_emit_take (emit_take)
    );

    ssort_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (DATA_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_req.we),
        .i_waddr   (ram_req.waddr),
        .i_wdata   (ram_req.wdata),
        .i_re      (ram_req.re),
        .i_raddr_a (ram_req.raddr_a),
        .i_raddr_b (ram_req.raddr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    assign emit_take = emit.valid && (!r_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (emit_take) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
        if (emit_take) begin
            r_value <= emit.value;
            r_last  <= emit.last;
            r_drop  <= emit.drop;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.sorted_value = r_value;
    assign o_out.last_out     = r_last;
    assign o_out.dropped      = r_drop;

endmodule
